### hw/rtl/mbd_pkg.sv
// ============================================================================
// mbd_pkg
// Shared types, constants and lane helpers of the 2x2 box downsampler.
// ============================================================================
package mbd_pkg;

    // Defaults for the largest source level that the line store can hold.
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_DATA_W-1:0]  DIM_RESET      = 11'd1024;

    // Texel channels, and pair sums packed as four 9-bit lanes.
    localparam int CHAN_W  = 8;
    localparam int LANE_W  = 9;
    localparam int LANES   = 4;
    localparam int PAIR_W  = LANE_W * LANES;
    localparam int COORD_W = 9;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [PAIR_W-1:0] pair_t;

    // Widens the four channels of a texel into the lane layout.
    function automatic pair_t pack_texel(chan_t r, chan_t g, chan_t b, chan_t a);
        pair_t p;
        p = {1'b0, a, 1'b0, b, 1'b0, g, 1'b0, r};
        return p;
    endfunction

    // Lane-wise add; a lane never exceeds two texels, so no carry crosses lanes.
    function automatic pair_t pair_add(pair_t x, pair_t y);
        pair_t s;
        for (int k = 0; k < LANES; k++)
        begin
            s[k*LANE_W +: LANE_W] = x[k*LANE_W +: LANE_W] + y[k*LANE_W +: LANE_W];
        end
        return s;
    endfunction

    // Mean of two pair sums, i.e. of four texels, truncated, for one lane.
    function automatic chan_t lane_mean(pair_t x, pair_t y, int k);
        logic [LANE_W:0] s;
        s = {1'b0, x[k*LANE_W +: LANE_W]} + {1'b0, y[k*LANE_W +: LANE_W]};
        return s[LANE_W:2];
    endfunction

endpackage

### hw/rtl/mbd_ram.sv
// ============================================================================
// mbd_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module mbd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/mipmap_box_downsample.sv
// ============================================================================
// mipmap_box_downsample
// A texel that completes a 2x2 block shows its result on out_valid after
// passing the block register, then the output register.
// Throughput: one source texel per cycle while in_stall is low; the line
// store has one write and one read port and each texel needs at most one.
// Reset: counters and valid flags clear, both size registers return to 1024;
// the line store is not cleared, so there is no start-up sweep.
// ============================================================================
module mipmap_box_downsample #(
    parameter int MAX_WIDTH  = mbd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mbd_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Source texel stream.
    input  logic                             in_valid,
    output logic                             in_stall,
    input  mbd_pkg::chan_t                   in_red,
    input  mbd_pkg::chan_t                   in_green,
    input  mbd_pkg::chan_t                   in_blue,
    input  mbd_pkg::chan_t                   in_alpha,
    // Downsampled texel stream.
    output logic                             out_valid,
    input  logic                             out_stall,
    output mbd_pkg::chan_t                   out_red,
    output mbd_pkg::chan_t                   out_green,
    output mbd_pkg::chan_t                   out_blue,
    output mbd_pkg::chan_t                   out_alpha,
    output logic [mbd_pkg::COORD_W-1:0]      out_col,
    output logic [mbd_pkg::COORD_W-1:0]      out_row,
    output logic                             last_texel,
    // Configuration writes.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mbd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mbd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import mbd_pkg::*;

    // The line store holds one pair sum per output column.
    localparam int STORE_DEPTH = MAX_WIDTH / 2;
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW = ($clog2(MAX_WIDTH) > AW + 1) ? $clog2(MAX_WIDTH) : AW + 1;
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    // ------------------------------------------------------------------------
    // Configuration registers. The port never pushes back; any write restarts
    // the level at its first texel.
    // ------------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] src_width_reg;
    logic [CFG_DATA_W-1:0] src_height_reg;
    logic                  cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= DIM_RESET;
            src_height_reg <= DIM_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                REG_SRC_HEIGHT: src_height_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Effective sizes: zero counts as one, anything past the store saturates.
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [WW-1:0] ow;
    logic [HW-1:0] oh;
    logic          w_one;
    logic          h_one;

    always_comb
    begin
        if (src_width_reg == '0)
            w_eff = WW'(1);
        else if (32'(src_width_reg) > 32'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(src_width_reg);

        if (src_height_reg == '0)
            h_eff = HW'(1);
        else if (32'(src_height_reg) > 32'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(src_height_reg);

        // Output size is half the source, but never below one texel.
        ow = ((w_eff >> 1) == '0) ? WW'(1) : (w_eff >> 1);
        oh = ((h_eff >> 1) == '0) ? HW'(1) : (h_eff >> 1);
        w_one = (w_eff == WW'(1));
        h_one = (h_eff == HW'(1));
    end

    // ------------------------------------------------------------------------
    // Input stage: horizontal pairing, line store access, position tracking.
    // ------------------------------------------------------------------------
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    pair_t         pair_sum_reg;
    pair_t         pair_sum_next;

    logic          in_accept;
    pair_t         texel;
    pair_t         pair;
    logic          have_pair;
    logic [AW-1:0] idx;
    logic          row_in_range;
    logic          store_wr;
    logic          store_rd;
    logic          emit;
    logic [RW-1:0] orow;
    logic          last_hit;

    assign in_accept = in_valid && !in_stall;
    assign texel     = pack_texel(in_red, in_green, in_blue, in_alpha);

    always_comb
    begin
        pair          = '0;
        have_pair     = 1'b0;
        idx           = '0;
        pair_sum_next = pair_sum_reg;

        if (w_one)
        begin
            // A one-texel-wide level pairs each texel with itself.
            pair      = pair_add(texel, texel);
            have_pair = 1'b1;
        end
        else if (32'(col_reg) < 32'(ow) * 2)
        begin
            if (!col_reg[0])
            begin
                pair_sum_next = texel;
            end
            else
            begin
                pair_sum_next = pair_add(pair_sum_reg, texel);
                pair          = pair_sum_next;
                have_pair     = 1'b1;
                idx           = AW'(col_reg >> 1);
            end
        end

        // Even rows park their pair sums; odd rows complete the block.
        row_in_range = (32'(row_reg) < 32'(oh) * 2);
        store_wr = have_pair && !h_one && row_in_range && !row_reg[0];
        store_rd = have_pair && !h_one && row_in_range && row_reg[0];
        emit     = have_pair && (h_one || (row_in_range && row_reg[0]));
        orow     = h_one ? '0 : (row_reg >> 1);
        last_hit = (32'(idx) == 32'(ow) - 1) && (32'(orow) == 32'(oh) - 1);

        // Raster advance; the level wraps to its first texel at the end.
        if (32'(col_reg) + 1 >= 32'(w_eff))
        begin
            col_next = '0;
            row_next = (32'(row_reg) + 1 >= 32'(h_eff)) ? '0 : row_reg + RW'(1);
        end
        else
        begin
            col_next = col_reg + CW'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            pair_sum_reg <= '0;
        end
        else if (cfg_write)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_accept)
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            pair_sum_reg <= pair_sum_next;
        end
    end

    pair_t store_rd_data;

    mbd_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (in_accept && store_wr),
        .wr_addr (idx),
        .wr_data (pair),
        .rd_en   (in_accept && store_rd),
        .rd_addr (idx),
        .rd_data (store_rd_data)
    );

    // ------------------------------------------------------------------------
    // Block register: holds a finished lower pair while the store read lands.
    // Its read data stays put because no new read is issued while it waits.
    // ------------------------------------------------------------------------
    logic                blk_valid_reg;
    pair_t               blk_pair_reg;
    logic                blk_self_reg;
    logic [COORD_W-1:0]  blk_col_reg;
    logic [COORD_W-1:0]  blk_row_reg;
    logic                blk_last_reg;
    logic                blk_advance;

    logic                out_valid_reg;
    chan_t               out_red_reg;
    chan_t               out_green_reg;
    chan_t               out_blue_reg;
    chan_t               out_alpha_reg;
    logic [COORD_W-1:0]  out_col_reg;
    logic [COORD_W-1:0]  out_row_reg;
    logic                out_last_reg;
    pair_t               upper_pair;

    // The block register moves on whenever the output register is free or
    // being emptied. Input is held off only when both are full and stuck.
    assign blk_advance = blk_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall    = blk_valid_reg && out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_valid_reg <= 1'b0;
        end
        else
        begin
            blk_valid_reg <= (in_accept && emit) || (blk_valid_reg && !blk_advance);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && emit)
        begin
            blk_pair_reg <= pair;
            blk_self_reg <= h_one;
            blk_col_reg  <= COORD_W'(idx);
            blk_row_reg  <= COORD_W'(orow);
            blk_last_reg <= last_hit;
        end
    end

    // ------------------------------------------------------------------------
    // Output register: vertical add and divide by four.
    // ------------------------------------------------------------------------
    assign upper_pair = blk_self_reg ? blk_pair_reg : store_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (blk_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (blk_advance)
        begin
            out_red_reg   <= lane_mean(blk_pair_reg, upper_pair, 0);
            out_green_reg <= lane_mean(blk_pair_reg, upper_pair, 1);
            out_blue_reg  <= lane_mean(blk_pair_reg, upper_pair, 2);
            out_alpha_reg <= lane_mean(blk_pair_reg, upper_pair, 3);
            out_col_reg   <= blk_col_reg;
            out_row_reg   <= blk_row_reg;
            out_last_reg  <= blk_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_red    = out_red_reg;
    assign out_green  = out_green_reg;
    assign out_blue   = out_blue_reg;
    assign out_alpha  = out_alpha_reg;
    assign out_col    = out_col_reg;
    assign out_row    = out_row_reg;
    assign last_texel = out_last_reg;

endmodule

### hw/rtl/mbd_checker.sv
// ============================================================================
// mbd_checker
// Port-level checks of the downsampler, bound to its top level.
// ============================================================================
module mbd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [7:0]                       out_red,
    input logic [7:0]                       out_alpha,
    input logic [mbd_pkg::COORD_W-1:0]      out_col,
    input logic                             last_texel,
    input logic                             cfg_ready
);

    import mbd_pkg::*;

    // A held result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A held result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_red) && $stable(out_alpha)
            && $stable(out_col) && $stable(last_texel))
        else $error("stalled result changed");

    // Input is only held off when a result is waiting and stuck.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // The configuration port never pushes back.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind mipmap_box_downsample mbd_checker u_mbd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_red    (out_red),
    .out_alpha  (out_alpha),
    .out_col    (out_col),
    .last_texel (last_texel),
    .cfg_ready  (cfg_ready)
);

### test/tb.sv
// ============================================================================
// tb
// Self-checking bench for the 2x2 box-filter mip downsampler. Source texels
// stream in under random idling on both sides. A behavioral model in this
// file works out every downsampled texel, and each output beat is compared
// field by field against the oldest one still owed.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mbd_pkg::*;

    // Cycles to let the pipeline empty before a register write. A result passes
    // the block and output registers, and a texel that completes nothing may
    // still be in flight when the last result has left.
    localparam int PIPE_CYCLES     = 4;
    // Cycles without any beat on any channel before the run is declared hung.
    localparam int STUCK_LIMIT     = 2000;
    // Random source texels per idling mode.
    localparam int RANDOM_PER_MODE = 100;
    // Longest random burst, and the texels sent into each of the largest levels.
    localparam int BURST_MAX       = 40;
    localparam int EXTREME_TEXELS  = 32;
    localparam int PLAN_ROWS       = 34;
    localparam int MAX_W           = MAX_WIDTH_DEF;
    localparam int MAX_H           = MAX_HEIGHT_DEF;

    // Register indexes past the end of the list. A write to them changes no
    // size but still restarts the level.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED3 = 2'd3;

    typedef struct packed {
        chan_t alpha;
        chan_t blue;
        chan_t green;
        chan_t red;
    } rgba_t;

    typedef struct packed {
        chan_t              red;
        chan_t              green;
        chan_t              blue;
        chan_t              alpha;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               is_last;
    } mip_texel_t;

    // Four 9-bit channel sums of a horizontal texel pair; lane 0 is red.
    typedef logic [3:0][8:0] hsum_t;

    typedef enum logic { ROW_WRITE, ROW_TEXEL } row_kind_t;

    // One row of the directed part: either a register write or one texel. When
    // typed is set, result holds the downsampled texel that the row must give.
    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
        rgba_t                  texel;
        logic                   typed;
        mip_texel_t             result;
    } plan_row_t;

    // ------------------------------------------------------------------------
    // Block ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   in_valid   = 1'b0;
    logic                   in_stall;
    chan_t                  in_red     = '0;
    chan_t                  in_green   = '0;
    chan_t                  in_blue    = '0;
    chan_t                  in_alpha   = '0;
    logic                   out_valid;
    logic                   out_stall  = 1'b0;
    chan_t                  out_red;
    chan_t                  out_green;
    chan_t                  out_blue;
    chan_t                  out_alpha;
    logic [COORD_W-1:0]     out_col;
    logic [COORD_W-1:0]     out_row;
    logic                   last_texel;
    logic                   cfg_valid  = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index  = '0;
    logic [CFG_DATA_W-1:0]  cfg_data   = '0;

    // ------------------------------------------------------------------------
    // Bench state.
    // ------------------------------------------------------------------------
    // Model of the block: size registers, raster position, the running pair
    // sum and the line store of even-row pair sums.
    logic [CFG_DATA_W-1:0]  model_width  = DIM_RESET;
    logic [CFG_DATA_W-1:0]  model_height = DIM_RESET;
    int unsigned            model_col    = 0;
    int unsigned            model_row    = 0;
    hsum_t                  run_acc      = '0;
    hsum_t                  line_store [0:MAX_W/2-1];

    // Downsampled texels still owed by the block, oldest first.
    mip_texel_t             owed_texels [$];

    // The sender tags a directed texel whose result is typed into the plan.
    logic                   typed_now    = 1'b0;
    mip_texel_t             typed_result = '0;

    int                     send_idle_pct = 0;
    int                     recv_idle_pct = 0;
    int                     mismatches     = 0;
    int                     texels_sent    = 0;
    int                     texels_checked = 0;
    int                     reg_writes     = 0;
    int                     stuck_cycles   = 0;

    plan_row_t              plan [0:PLAN_ROWS-1];

    mipmap_box_downsample DUT (.*);

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver decides each cycle, at the falling edge, whether to stall.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Model helpers.
    // ------------------------------------------------------------------------
    // A size of zero counts as one; a size past the line store saturates.
    function automatic int unsigned eff_dim(logic [CFG_DATA_W-1:0] v, int unsigned cap);
        if (v == 0)
            return 1;
        if (v > cap)
            return cap;
        return 32'(v);
    endfunction

    // Truncated mean of four texels, given as two pair sums of one channel.
    function automatic chan_t quarter(logic [8:0] a, logic [8:0] b);
        int unsigned s;
        s = 32'(a) + 32'(b);
        return chan_t'(s / 4);
    endfunction

    // Advances the model by one source texel. made tells whether the texel
    // closes a 2x2 block, and res is the resulting texel of the smaller level.
    task automatic box_average(input rgba_t px, output bit made, output mip_texel_t res);
        int unsigned w;
        int unsigned h;
        int unsigned ow;
        int unsigned oh;
        int unsigned slot;
        int unsigned dst_row;
        hsum_t       t;
        hsum_t       pair;
        hsum_t       other;
        bit          have;
        w       = eff_dim(model_width, MAX_W);
        h       = eff_dim(model_height, MAX_H);
        ow      = (w / 2 != 0) ? w / 2 : 1;
        oh      = (h / 2 != 0) ? h / 2 : 1;
        t[0]    = {1'b0, px.red};
        t[1]    = {1'b0, px.green};
        t[2]    = {1'b0, px.blue};
        t[3]    = {1'b0, px.alpha};
        pair    = '0;
        other   = '0;
        have    = 1'b0;
        made    = 1'b0;
        slot    = 0;
        dst_row = 0;
        res     = '0;

        // Horizontal pairing. A one-texel-wide level pairs each texel with
        // itself; an odd trailing column pairs with nothing.
        if (w == 1)
        begin
            for (int k = 0; k < 4; k++)
                pair[k] = t[k] << 1;
            have = 1'b1;
        end
        else if (model_col < 2 * ow)
        begin
            if (model_col % 2 == 0)
                run_acc = t;
            else
            begin
                for (int k = 0; k < 4; k++)
                    run_acc[k] = run_acc[k] + t[k];
                pair = run_acc;
                have = 1'b1;
                slot = model_col / 2;
            end
        end

        // Vertical pairing through the line store, with the same rules.
        if (have)
        begin
            if (h == 1)
            begin
                other = pair;
                made  = 1'b1;
            end
            else if (model_row < 2 * oh)
            begin
                if (model_row % 2 == 0)
                    line_store[slot] = pair;
                else
                begin
                    other   = line_store[slot];
                    made    = 1'b1;
                    dst_row = model_row / 2;
                end
            end
        end

        if (made)
        begin
            res.red     = quarter(pair[0], other[0]);
            res.green   = quarter(pair[1], other[1]);
            res.blue    = quarter(pair[2], other[2]);
            res.alpha   = quarter(pair[3], other[3]);
            res.col     = COORD_W'(slot);
            res.row     = COORD_W'(dst_row);
            res.is_last = (slot == ow - 1) && (dst_row == oh - 1);
        end

        // Raster advance; the level wraps after its last source texel.
        model_col++;
        if (model_col >= w)
        begin
            model_col = 0;
            model_row++;
            if (model_row >= h)
                model_row = 0;
        end
    endtask

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Beat monitor. All three channels are sampled at the rising edge, so the
    // model sees register writes, texels and results in the order they happen.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        mip_texel_t got;
        mip_texel_t calc;
        mip_texel_t want;
        bit         made;
        bit         beat;
        beat = 1'b0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_SRC_WIDTH)
                    model_width = cfg_data;
                else if (cfg_index == REG_SRC_HEIGHT)
                    model_height = cfg_data;
                // Any write, to a known register or not, restarts the level.
                model_col = 0;
                model_row = 0;
                reg_writes++;
                beat = 1'b1;
            end

            if (in_valid && !in_stall)
            begin
                box_average(rgba_t'({in_alpha, in_blue, in_green, in_red}), made, calc);
                // The model still runs on typed rows so that its state stays
                // in step; the typed value is what gets checked.
                if (typed_now)
                    owed_texels.push_back(typed_result);
                else if (made)
                    owed_texels.push_back(calc);
                texels_sent++;
                beat = 1'b1;
            end

            if (out_valid && !out_stall)
            begin
                got.red     = out_red;
                got.green   = out_green;
                got.blue    = out_blue;
                got.alpha   = out_alpha;
                got.col     = out_col;
                got.row     = out_row;
                got.is_last = last_texel;
                if (owed_texels.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected beat, expected none, actual col %0d row %0d rgba %h",
                             $time, got.col, got.row,
                             {got.red, got.green, got.blue, got.alpha});
                end
                else
                begin
                    want = owed_texels.pop_front();
                    check_field("out_red", want.red, got.red);
                    check_field("out_green", want.green, got.green);
                    check_field("out_blue", want.blue, got.blue);
                    check_field("out_alpha", want.alpha, got.alpha);
                    check_field("out_col", want.col, got.col);
                    check_field("out_row", want.row, got.row);
                    check_field("last_texel", want.is_last, got.is_last);
                end
                texels_checked++;
                beat = 1'b1;
            end
        end
        stuck_cycles <= beat ? 0 : stuck_cycles + 1;
    end

    // Watchdog: a run that stops moving is a failure.
    initial
    begin
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("%0t: no beat on any channel for %0d cycles, %0d results still owed",
                 $time, STUCK_LIMIT, owed_texels.size());
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks. Inputs change at the falling edge only.
    // ------------------------------------------------------------------------
    // Offers one texel, after random idle cycles, and holds it until a rising
    // edge accepts it.
    task automatic send_texel(input rgba_t px, input logic typed, input mip_texel_t res);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        in_red       <= px.red;
        in_green     <= px.green;
        in_blue      <= px.blue;
        in_alpha     <= px.alpha;
        typed_now    <= typed;
        typed_result <= res;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic stream_texels(input int unsigned count);
        repeat (count)
            send_texel(rgba_t'($urandom), 1'b0, '0);
    endtask

    // Stops the source and waits until every owed result has come out and
    // the pipeline has had time to empty.
    task automatic drain_level();
        @(negedge clk);
        in_valid  <= 1'b0;
        typed_now <= 1'b0;
        while (owed_texels.size() != 0)
            @(posedge clk);
        repeat (PIPE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly small sizes, now and then zero or a medium width or height.
    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        int unsigned roll;
        roll = $urandom_range(15);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return CFG_DATA_W'($urandom_range(9, 20));
        return CFG_DATA_W'($urandom_range(1, 8));
    endfunction

    // One random level: new sizes (or a restart alone), then mostly whole
    // levels, sometimes running into the next one, sometimes cut short.
    task automatic random_phase();
        int unsigned roll;
        int unsigned full;
        int unsigned count;
        drain_level();
        roll = $urandom_range(9);
        if (roll == 0)
            write_reg(($urandom_range(1) != 0) ? REG_UNUSED3 : REG_UNUSED2,
                      CFG_DATA_W'($urandom_range(2047)));
        if (roll != 0 && roll != 2)
            write_reg(REG_SRC_WIDTH, pick_dim());
        if (roll != 0 && roll != 1)
            write_reg(REG_SRC_HEIGHT, pick_dim());
        full = eff_dim(model_width, MAX_W) * eff_dim(model_height, MAX_H);
        if ($urandom_range(3) == 0)
            count = $urandom_range(1, full);
        else
            count = full * $urandom_range(1, 2) + $urandom_range(2);
        if (count > BURST_MAX)
            count = BURST_MAX;
        stream_texels(count);
    endtask

    // The largest sizes: the opening stretch of a full-width single row and of a
    // full-height single column, both reached through saturation, and of a
    // 1024x1024 level.
    task automatic extreme_levels();
        drain_level();
        write_reg(REG_SRC_WIDTH, 11'd2047);
        write_reg(REG_SRC_HEIGHT, 11'd1);
        stream_texels(EXTREME_TEXELS);
        drain_level();
        write_reg(REG_SRC_WIDTH, 11'd1);
        write_reg(REG_SRC_HEIGHT, 11'd2047);
        stream_texels(EXTREME_TEXELS);
        drain_level();
        write_reg(REG_SRC_WIDTH, 11'd1024);
        write_reg(REG_SRC_HEIGHT, 11'd1024);
        stream_texels(EXTREME_TEXELS);
    endtask

    // Builders for the directed plan.
    function automatic plan_row_t write_row(logic [CFG_INDEX_W-1:0] index,
                                            logic [CFG_DATA_W-1:0] data);
        plan_row_t r;
        r       = '0;
        r.kind  = ROW_WRITE;
        r.index = index;
        r.data  = data;
        return r;
    endfunction

    function automatic plan_row_t texel_row(rgba_t px);
        plan_row_t r;
        r       = '0;
        r.kind  = ROW_TEXEL;
        r.texel = px;
        return r;
    endfunction

    function automatic plan_row_t known_row(rgba_t px, mip_texel_t res);
        plan_row_t r;
        r        = texel_row(px);
        r.typed  = 1'b1;
        r.result = res;
        return r;
    endfunction

    function automatic mip_texel_t mip(rgba_t px, int unsigned col, int unsigned row,
                                       logic is_last);
        mip_texel_t m;
        m.red     = px.red;
        m.green   = px.green;
        m.blue    = px.blue;
        m.alpha   = px.alpha;
        m.col     = COORD_W'(col);
        m.row     = COORD_W'(row);
        m.is_last = is_last;
        return m;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        int mark;

        // Texels are written as 32'hAABBGGRR.
        plan = '{
            // Two texels at the reset size of 1024x1024: the first row only
            // fills the line store, so nothing comes out.
            texel_row(32'hFFFFFFFF),
            texel_row(32'h00000000),
            // Zero sizes count as one. In a 1x1 level every texel is its own
            // block and comes back unchanged as the last texel of the level.
            write_row(REG_SRC_WIDTH, 11'd0),
            write_row(REG_SRC_HEIGHT, 11'd0),
            known_row(32'h00000000, mip(32'h00000000, 0, 0, 1'b1)),
            known_row(32'hFFFFFFFF, mip(32'hFFFFFFFF, 0, 0, 1'b1)),
            known_row(32'h8001A55A, mip(32'h8001A55A, 0, 0, 1'b1)),
            // A 2x1 level: the single row counts twice, so white next to
            // black truncates to 0x7F in every channel.
            write_row(REG_SRC_WIDTH, 11'd2),
            write_row(REG_SRC_HEIGHT, 11'd1),
            texel_row(32'hFFFFFFFF),
            known_row(32'h00000000, mip(32'h7F7F7F7F, 0, 0, 1'b1)),
            // A 2x3 level: the odd trailing row only moves the counters, and
            // the level wraps afterwards.
            write_row(REG_SRC_HEIGHT, 11'd3),
            texel_row(32'h11223344),
            texel_row(32'h55667788),
            texel_row(32'h99AABBCC),
            texel_row(32'hDDEEFF00),
            texel_row(32'h0F1E2D3C),
            texel_row(32'hF0E1D2C3),
            // A write past the register list restarts the level and nothing else.
            write_row(REG_UNUSED2, 11'd2047),
            texel_row(32'h80808080),
            texel_row(32'h7F7F7F7F),
            texel_row(32'h01010101),
            texel_row(32'hFEFEFEFE),
            write_row(REG_UNUSED3, 11'd0),
            // A 3x1 level: the odd trailing column is dropped, and the fourth
            // texel starts the next level.
            write_row(REG_SRC_HEIGHT, 11'd1),
            write_row(REG_SRC_WIDTH, 11'd3),
            texel_row(32'hAAAAAAAA),
            texel_row(32'h55555555),
            texel_row(32'h12345678),
            texel_row(32'h9ABCDEF0),
            // A 1x2 level: the single column counts twice.
            write_row(REG_SRC_WIDTH, 11'd1),
            write_row(REG_SRC_HEIGHT, 11'd2),
            texel_row(32'hC3C3C3C3),
            texel_row(32'h3C3C3C3C)
        };

        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Three idling modes: a slow receiver, then a slow sender, then
        // neither side idles. The directed plan and the largest levels run
        // in the first mode.
        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    send_idle_pct = 35;
                    recv_idle_pct = 82;
                end
                1:
                begin
                    send_idle_pct = 82;
                    recv_idle_pct = 35;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            if (mode == 0)
            begin
                foreach (plan[i])
                begin
                    if (plan[i].kind == ROW_WRITE)
                    begin
                        drain_level();
                        write_reg(plan[i].index, plan[i].data);
                    end
                    else
                        send_texel(plan[i].texel, plan[i].typed, plan[i].result);
                end
                extreme_levels();
            end

            mark = texels_sent;
            while (texels_sent - mark < RANDOM_PER_MODE)
                random_phase();
        end

        drain_level();

        $display("Run covered %0d source texels and %0d register writes; %0d mip texels checked.",
                 texels_sent, reg_writes, texels_checked);
        $display("Sizes ranged from 1x1 up to 1024 on each side, with zero and saturating values.");
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
